// ===== hdl/imhq_pkg.sv =====
`timescale 1ns / 1ps
package imhq_pkg;
    localparam int ITEMS = 1024;
    localparam int IW = $clog2(ITEMS);
    localparam int PW = $clog2(ITEMS + 1);

    localparam logic [1:0] REQ_TOUCH   = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_DELETE  = 2'd2;
    localparam logic [1:0] REQ_FLUSH   = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [9:0]        item_id;
        logic signed [31:0] new_score;
    } t_in;

    typedef struct packed {
        logic              out_valid;
        logic [9:0]        out_id;
        logic signed [31:0] out_score;
        logic              in_queue;
        logic [10:0]       occupancy;
    } t_out;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_ID, ST_DECIDE, ST_DQ_RD, ST_DQ_SC,
        ST_RM_RD, ST_RM_SC, ST_RM_PAR, ST_RM_PSC, ST_RM_CMP,
        ST_UP_RD, ST_UP_SC, ST_UP_CMP,
        ST_DN_RDL, ST_DN_RDR, ST_DN_SCL, ST_DN_SCR, ST_DN_CMP,
        ST_PLACE, ST_FL_RD, ST_FL_WR, ST_DONE, ST_REPLY
    } t_state;
endpackage

// ===== hdl/imhq_ram.sv =====
`timescale 1ns / 1ps
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/indexed_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_stall    | i_in   (imhq_pkg::t_in)
// output  | out       | o_out_valid / i_out_stall  | o_out  (imhq_pkg::t_out)
// config  | in        | i_cfg_we                   | i_cfg_data (score_limit)
// One item is worked at a time. A level of sift-up steps through ST_UP_RD, ST_UP_SC
// and ST_UP_CMP, a level of sift-down through ST_DN_RDL, ST_DN_RDR, ST_DN_SCL,
// ST_DN_SCR and ST_DN_CMP; a flush clears each queued entry in ST_FL_RD, ST_FL_WR.
// After reset a clearing pass zeroes the position map.
// The result waits in an output register; the next item is taken while it waits,
// unless the receiver is stalling it.
module indexed_min_heap_queue_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  imhq_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output imhq_pkg::t_out     o_out,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_data
);
    localparam int IW = imhq_pkg::IW;
    localparam int PW = imhq_pkg::PW;

    imhq_pkg::t_state r_st, n_st;
    logic signed [31:0] r_lim;
    imhq_pkg::t_in r_req, n_req;
    logic [PW-1:0] r_cnt, n_cnt, r_p, n_p, r_c, n_c, r_i, n_i;
    logic [IW-1:0] r_id, n_id, r_par, n_par, r_lid, n_lid, r_rid, n_rid;
    logic signed [31:0] r_s, n_s, r_ps, n_ps, r_ls, n_ls;
    logic r_dq, n_dq;
    logic [IW-1:0] r_dqid, n_dqid;
    logic signed [31:0] r_dqs, n_dqs;
    logic r_ov, n_ov;
    imhq_pkg::t_out r_out, n_out;

    // heap slots
    logic h_we; logic [PW-1:0] h_wa, h_ra; logic [IW-1:0] h_wd, h_rd;
    // position map
    logic p_we; logic [IW-1:0] p_wa, p_ra; logic [PW-1:0] p_wd, p_rd;
    // scores
    logic s_we; logic [IW-1:0] s_wa, s_ra; logic signed [31:0] s_wd, s_rd;

    imhq_ram #(.WIDTH(IW), .DEPTH(imhq_pkg::ITEMS + 1)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd));
    imhq_ram #(.WIDTH(PW), .DEPTH(imhq_pkg::ITEMS)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));
    imhq_ram #(.WIDTH(32), .DEPTH(imhq_pkg::ITEMS)) u_score (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));

    assign o_in_stall  = (r_st != imhq_pkg::ST_IDLE) || (r_ov && i_out_stall);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= imhq_pkg::ST_CLEAR;
            r_lim <= 32'sh7FFFFFFF;
            r_cnt <= '0;
            r_i <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_i <= n_i;
            r_ov <= n_ov;
            if (i_cfg_we) r_lim <= i_cfg_data;
        end
        r_req <= n_req; r_p <= n_p; r_c <= n_c; r_id <= n_id; r_par <= n_par;
        r_lid <= n_lid; r_rid <= n_rid; r_s <= n_s; r_ps <= n_ps; r_ls <= n_ls;
        r_dq <= n_dq; r_dqid <= n_dqid; r_dqs <= n_dqs; r_out <= n_out;
    end

    always_comb begin
        n_st = r_st; n_req = r_req; n_cnt = r_cnt; n_p = r_p; n_c = r_c;
        n_i = r_i; n_id = r_id; n_par = r_par; n_lid = r_lid; n_rid = r_rid;
        n_s = r_s; n_ps = r_ps; n_ls = r_ls; n_dq = r_dq; n_dqid = r_dqid;
        n_dqs = r_dqs; n_out = r_out;
        n_ov = r_ov && i_out_stall;
        h_we = 1'b0; h_wa = r_p; h_wd = r_id; h_ra = r_p;
        p_we = 1'b0; p_wa = r_id; p_wd = r_p; p_ra = r_id;
        s_we = 1'b0; s_wa = r_req.item_id; s_wd = r_req.new_score; s_ra = r_id;
        case (r_st)
            imhq_pkg::ST_CLEAR: begin
                p_we = 1'b1; p_wa = r_i[IW-1:0]; p_wd = '0;
                n_i = r_i + 1'b1;
                if (r_i == PW'(imhq_pkg::ITEMS - 1)) begin
                    n_i = '0;
                    n_st = imhq_pkg::ST_IDLE;
                end
            end
            imhq_pkg::ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_req = i_in; n_id = i_in.item_id; n_dq = 1'b0;
                    n_dqid = '0; n_dqs = '0;
                    p_ra = i_in.item_id; s_ra = i_in.item_id;
                    h_ra = PW'(1);
                    case (i_in.req_type)
                        imhq_pkg::REQ_DEQUEUE:
                            n_st = (r_cnt == '0) ? imhq_pkg::ST_DONE
                                                 : imhq_pkg::ST_DQ_RD;
                        imhq_pkg::REQ_FLUSH: begin
                            n_i = PW'(1);
                            n_st = (r_cnt == '0) ? imhq_pkg::ST_DONE
                                                 : imhq_pkg::ST_FL_RD;
                        end
                        default: n_st = imhq_pkg::ST_RD_ID;
                    endcase
                end
            end
            imhq_pkg::ST_RD_ID: begin
                // position and old score of the id are now on the read ports
                n_p = p_rd; n_ps = s_rd; n_s = r_req.new_score;
                n_st = imhq_pkg::ST_DECIDE;
            end
            imhq_pkg::ST_DECIDE: begin
                n_st = imhq_pkg::ST_DONE;
                if (r_req.req_type == imhq_pkg::REQ_TOUCH) begin
                    s_we = 1'b1;
                    if (r_p == '0) begin
                        if (r_s <= r_lim &&
                            r_cnt < PW'(imhq_pkg::ITEMS)) begin
                            n_cnt = r_cnt + 1'b1;
                            n_p = r_cnt + 1'b1;
                            n_st = imhq_pkg::ST_UP_RD;
                        end
                    end else if (r_s > r_lim) begin
                        n_st = imhq_pkg::ST_RM_RD;
                    end else if (r_s < r_ps) begin
                        n_st = imhq_pkg::ST_UP_RD;
                    end else begin
                        n_st = imhq_pkg::ST_DN_RDL;
                    end
                end else if (r_p != '0) begin
                    n_st = imhq_pkg::ST_RM_RD;
                end
            end
            imhq_pkg::ST_DQ_RD: begin
                n_id = h_rd; s_ra = h_rd; p_ra = h_rd;
                n_st = imhq_pkg::ST_DQ_SC;
            end
            imhq_pkg::ST_DQ_SC: begin
                n_dq = 1'b1; n_dqid = r_id; n_dqs = s_rd; n_p = PW'(1);
                n_st = imhq_pkg::ST_RM_RD;
            end
            imhq_pkg::ST_RM_RD: begin
                // clear own entry, fetch the last slot
                p_we = 1'b1; p_wa = r_id; p_wd = '0;
                h_ra = r_cnt;
                n_cnt = r_cnt - 1'b1;
                n_st = (r_p == r_cnt) ? imhq_pkg::ST_DONE : imhq_pkg::ST_RM_SC;
            end
            imhq_pkg::ST_RM_SC: begin
                n_rid = h_rd; s_ra = h_rd; h_ra = r_p >> 1;
                n_st = imhq_pkg::ST_RM_PAR;
            end
            imhq_pkg::ST_RM_PAR: begin
                n_s = s_rd; n_par = h_rd; s_ra = h_rd;
                n_st = imhq_pkg::ST_RM_PSC;
            end
            imhq_pkg::ST_RM_PSC: begin
                n_ps = s_rd; n_id = r_rid;
                n_st = imhq_pkg::ST_RM_CMP;
            end
            imhq_pkg::ST_RM_CMP: begin
                n_st = (r_p > PW'(1) && r_ps > r_s) ? imhq_pkg::ST_UP_RD
                                                     : imhq_pkg::ST_DN_RDL;
            end
            imhq_pkg::ST_UP_RD: begin
                h_ra = r_p >> 1;
                n_st = (r_p > PW'(1)) ? imhq_pkg::ST_UP_SC : imhq_pkg::ST_PLACE;
            end
            imhq_pkg::ST_UP_SC: begin
                n_par = h_rd; s_ra = h_rd;
                n_st = imhq_pkg::ST_UP_CMP;
            end
            imhq_pkg::ST_UP_CMP: begin
                if (s_rd <= r_s) begin
                    n_st = imhq_pkg::ST_PLACE;
                end else begin
                    h_we = 1'b1; h_wa = r_p; h_wd = r_par;
                    p_we = 1'b1; p_wa = r_par; p_wd = r_p;
                    n_p = r_p >> 1;
                    n_st = imhq_pkg::ST_UP_RD;
                end
            end
            imhq_pkg::ST_DN_RDL: begin
                h_ra = r_p << 1;
                n_c = r_p << 1;
                if ({1'b0, r_p} << 1 > {1'b0, r_cnt})
                    n_st = imhq_pkg::ST_PLACE;
                else
                    n_st = imhq_pkg::ST_DN_RDR;
            end
            imhq_pkg::ST_DN_RDR: begin
                n_lid = h_rd; s_ra = h_rd; h_ra = r_c + 1'b1;
                n_st = imhq_pkg::ST_DN_SCL;
            end
            imhq_pkg::ST_DN_SCL: begin
                n_ls = s_rd; n_rid = h_rd; s_ra = h_rd;
                n_st = imhq_pkg::ST_DN_SCR;
            end
            imhq_pkg::ST_DN_SCR: begin
                if ({1'b0, r_c} + 1'b1 <= {1'b0, r_cnt} && r_ls > s_rd) begin
                    n_c = r_c + 1'b1; n_lid = r_rid; n_ls = s_rd;
                end
                n_st = imhq_pkg::ST_DN_CMP;
            end
            imhq_pkg::ST_DN_CMP: begin
                if (r_ls >= r_s) begin
                    n_st = imhq_pkg::ST_PLACE;
                end else begin
                    h_we = 1'b1; h_wa = r_p; h_wd = r_lid;
                    p_we = 1'b1; p_wa = r_lid; p_wd = r_p;
                    n_p = r_c;
                    n_st = imhq_pkg::ST_DN_RDL;
                end
            end
            imhq_pkg::ST_PLACE: begin
                h_we = 1'b1; h_wa = r_p; h_wd = r_id;
                p_we = 1'b1; p_wa = r_id; p_wd = r_p;
                n_st = imhq_pkg::ST_DONE;
            end
            imhq_pkg::ST_FL_RD: begin
                h_ra = r_i;
                n_st = imhq_pkg::ST_FL_WR;
            end
            imhq_pkg::ST_FL_WR: begin
                p_we = 1'b1; p_wa = h_rd; p_wd = '0;
                n_i = r_i + 1'b1;
                if (r_i == r_cnt) begin
                    n_cnt = '0;
                    n_st = imhq_pkg::ST_DONE;
                end else begin
                    n_st = imhq_pkg::ST_FL_RD;
                end
            end
            imhq_pkg::ST_DONE: begin
                // The position of the requested id is read once more for the result.
                p_ra = r_req.item_id;
                n_st = imhq_pkg::ST_REPLY;
            end
            imhq_pkg::ST_REPLY: begin
                p_ra = r_req.item_id;
                if (!(r_ov && i_out_stall)) begin
                    n_ov = 1'b1;
                    n_out.out_valid = r_dq;
                    n_out.out_id = r_dqid;
                    n_out.out_score = r_dqs;
                    n_out.in_queue = (p_rd != '0);
                    n_out.occupancy = 11'(r_cnt);
                    n_st = imhq_pkg::ST_IDLE;
                end
            end
            default: n_st = imhq_pkg::ST_IDLE;
        endcase
    end
endmodule
